@@ design/ppcc_pkg.sv @@
// Shared constants for the partition path cut cost block.
// Holds field widths, register indexes and reset values; depends on nothing.
`default_nettype none

package ppcc_pkg;

   // Field widths of the item on each side.
   localparam int BLOCK_ID_W  = 6;
   localparam int WEIGHT_W    = 16;
   localparam int FACTOR_W    = 16;
   localparam int COST_W      = 43;
   localparam int OUT_CNT_W   = 10;

   // Packed bus widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 64;

   // Widest counter the design supports; counts are widened to this before clipping.
   localparam int CNT_EXT_W   = 16;

   // Largest value of a result count field.
   localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

   // Largest path cost, all ones in the cost field.
   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Defaults of the top-level parameters.
   localparam int NUM_BLOCKS_DEF = 64;
   localparam int COUNT_BITS_DEF = 10;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMING_FACTOR  = 1'b0,
      CSR_SNAKING_FACTOR = 1'b1
   } csr_index_type;

   // Reset values of the configuration registers (1.0 in Q8.8).
   localparam logic [FACTOR_W-1:0] TIMING_FACTOR_RST  = 16'd256;
   localparam logic [FACTOR_W-1:0] SNAKING_FACTOR_RST = 16'd256;

endpackage

`default_nettype wire

@@ design/partition_path_cut_cost.sv @@
// Partition path cut cost evaluator: top level and its only module.
// Depends on ppcc_pkg for widths, register indexes and reset values.
`default_nettype none

// One vertex item is taken per cycle within a path. The per-block entry counters live in
// a synchronous memory: the block's count is read when a vertex is accepted and the
// incremented count is written back at the next clock edge, while the next vertex follows
// right behind. The end-of-path vertex drives the cost pipeline (a 16x16 and a 16xCOUNT_BITS
// product, the cut multiply, then the saturating sum into the output register); the next
// path's first vertex is accepted once that result has been taken on rsp. Per-path
// state is cleared at once by the end vertex: the counter memory has per-entry valid
// flops, so no clearing pass is needed after reset or between paths. Blocks at or above
// NUM_BLOCKS still count as cuts but are not counted as entries.
module partition_path_cut_cost #(
   parameter int NUM_BLOCKS = ppcc_pkg::NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = ppcc_pkg::COUNT_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Vertex items.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: vertex_block[5:0], path_weight[21:6], zero fill.
   input  wire  [ppcc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // end_of_path.
   input  wire                                   req_tlast,
   // Result items.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // Fields from bit 0: total_cost[42:0], cut_count[52:43], max_entries[62:53], zero fill.
   output logic [ppcc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration writes.
   input  wire                                   csr_wr_en,
   input  wire  [ppcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [ppcc_pkg::FACTOR_W-1:0]         csr_wr_data
);

   // Only 64 block numbers can be addressed, so the memory never needs more rows.
   localparam int ID_SPAN   = 1 << ppcc_pkg::BLOCK_ID_W;
   localparam int MEM_DEPTH = (NUM_BLOCKS < ID_SPAN) ? NUM_BLOCKS : ID_SPAN;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int P1_W      = 2 * ppcc_pkg::FACTOR_W;
   localparam int T_W       = P1_W + COUNT_BITS;
   localparam int S_W       = ppcc_pkg::FACTOR_W + COUNT_BITS;
   localparam int SUM_W     = (T_W > ppcc_pkg::COST_W) ? T_W + 1 : ppcc_pkg::COST_W + 1;
   localparam int SNAKE_SH  = 12;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Saturating counter increment.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Clip a count to the result field width.
   function automatic logic [ppcc_pkg::OUT_CNT_W-1:0] clip_cnt(
      input logic [COUNT_BITS-1:0] v
   );
      logic [ppcc_pkg::CNT_EXT_W-1:0] ext;
      ext = ppcc_pkg::CNT_EXT_W'(v);
      if (ext > ppcc_pkg::CNT_EXT_W'(ppcc_pkg::OUT_CNT_MAX)) begin
         clip_cnt = ppcc_pkg::OUT_CNT_MAX;
      end else begin
         clip_cnt = ext[ppcc_pkg::OUT_CNT_W-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- declarations
   logic [ppcc_pkg::FACTOR_W-1:0]   timing_factor_ff;
   logic [ppcc_pkg::FACTOR_W-1:0]   snaking_factor_ff;

   logic [ppcc_pkg::BLOCK_ID_W-1:0] in_block;
   logic [ppcc_pkg::WEIGHT_W-1:0]   in_weight;
   logic                            req_take;
   logic                            in_visit;
   logic                            in_counted;
   logic [ADDR_W-1:0]               in_addr;

   logic [ppcc_pkg::BLOCK_ID_W-1:0] prev_block_ff;
   logic                            have_prev_ff;

   logic [COUNT_BITS-1:0]           entry_mem [MEM_DEPTH];
   logic [COUNT_BITS-1:0]           rd_data_ff;
   logic [MEM_DEPTH-1:0]            cnt_vld_ff;

   logic                            s1_vld_ff;
   logic                            s1_visit_ff;
   logic                            s1_cut_ff;
   logic                            s1_counted_ff;
   logic                            s1_last_ff;
   logic [ADDR_W-1:0]               s1_addr_ff;
   logic [ppcc_pkg::WEIGHT_W-1:0]   s1_weight_ff;

   logic [COUNT_BITS-1:0]           cuts_ff;
   logic [COUNT_BITS-1:0]           max_ff;
   logic [COUNT_BITS-1:0]           entry_in;
   logic                            cnt_wr;
   logic [COUNT_BITS-1:0]           cuts_in;
   logic [COUNT_BITS-1:0]           max_in;
   logic                            s1_end;

   logic                            c2_vld_ff;
   logic [COUNT_BITS-1:0]           c2_cuts_ff;
   logic [COUNT_BITS-1:0]           c2_max_ff;
   logic [ppcc_pkg::WEIGHT_W-1:0]   c2_weight_ff;
   logic [COUNT_BITS-1:0]           c2_rep;

   logic                            c3_vld_ff;
   logic [COUNT_BITS-1:0]           c3_cuts_ff;
   logic [COUNT_BITS-1:0]           c3_max_ff;
   logic [P1_W-1:0]                 c3_p1_ff;
   logic [S_W-1:0]                  c3_snake_ff;

   logic                            c4_vld_ff;
   logic [COUNT_BITS-1:0]           c4_cuts_ff;
   logic [COUNT_BITS-1:0]           c4_max_ff;
   logic [T_W-1:0]                  c4_timing_ff;
   logic [S_W-1:0]                  c4_snake_ff;

   logic [SUM_W-1:0]                cost_sum;
   logic [ppcc_pkg::COST_W-1:0]     cost_in;

   logic                            rsp_vld_ff;
   logic [ppcc_pkg::COST_W-1:0]     rsp_cost_ff;
   logic [ppcc_pkg::OUT_CNT_W-1:0]  rsp_cuts_ff;
   logic [ppcc_pkg::OUT_CNT_W-1:0]  rsp_max_ff;
   logic                            cost_busy;

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_factor_ff  <= ppcc_pkg::TIMING_FACTOR_RST;
         snaking_factor_ff <= ppcc_pkg::SNAKING_FACTOR_RST;
      end else if (csr_wr_en) begin
         case (ppcc_pkg::csr_index_type'(csr_index))
            ppcc_pkg::CSR_TIMING_FACTOR:  timing_factor_ff  <= csr_wr_data;
            ppcc_pkg::CSR_SNAKING_FACTOR: snaking_factor_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input side
   assign in_block  = req_tdata[ppcc_pkg::BLOCK_ID_W-1:0];
   assign in_weight = req_tdata[ppcc_pkg::BLOCK_ID_W +: ppcc_pkg::WEIGHT_W];

   // A vertex waits until the cost pipeline is free and any end vertex has left stage one.
   assign cost_busy  = c2_vld_ff | c3_vld_ff | c4_vld_ff | rsp_vld_ff;
   assign req_tready = !cost_busy && !(s1_vld_ff && s1_last_ff);
   assign req_take   = req_tvalid && req_tready;

   // A vertex starts a new visit when the block changes or the path just began.
   assign in_visit   = !have_prev_ff || (in_block != prev_block_ff);
   assign in_counted = (32'(in_block) < 32'(NUM_BLOCKS));
   assign in_addr    = in_block[ADDR_W-1:0];

   // Previous block tracking, cleared by the end vertex.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_block_ff <= '0;
         have_prev_ff  <= 1'b0;
      end else if (req_take) begin
         if (req_tlast) begin
            prev_block_ff <= '0;
            have_prev_ff  <= 1'b0;
         end else if (in_visit) begin
            prev_block_ff <= in_block;
            have_prev_ff  <= 1'b1;
         end
      end
   end

   // Stage one control: the vertex whose counter read is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_visit_ff   <= in_visit;
         s1_cut_ff     <= in_visit && have_prev_ff;
         s1_counted_ff <= in_counted;
         s1_last_ff    <= req_tlast;
         s1_addr_ff    <= in_addr;
         s1_weight_ff  <= in_weight;
      end
   end

   // ---------------------------------------------------------------- counter memory
   // A vertex that reads the row being written in the same cycle repeats the block of
   // the vertex before it, so it is no visit and its stale read data is never used.
   // The next path cannot start before the end vertex has left stage one.
   always_ff @(posedge clock) begin
      if (req_take && in_counted) begin
         rd_data_ff <= entry_mem[in_addr];
      end
      if (cnt_wr) begin
         entry_mem[s1_addr_ff] <= entry_in;
      end
   end

   // Stage one update of the entry count, cut count and largest entry count.
   assign cnt_wr   = s1_vld_ff && s1_visit_ff && s1_counted_ff;
   assign entry_in = cnt_vld_ff[s1_addr_ff] ? sat_inc(rd_data_ff) : COUNT_BITS'(1);
   assign cuts_in  = s1_cut_ff ? sat_inc(cuts_ff) : cuts_ff;
   assign max_in   = (cnt_wr && (entry_in > max_ff)) ? entry_in : max_ff;
   assign s1_end   = s1_vld_ff && s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cuts_ff    <= '0;
         max_ff     <= '0;
         cnt_vld_ff <= '0;
      end else if (s1_end) begin
         cuts_ff    <= '0;
         max_ff     <= '0;
         cnt_vld_ff <= '0;
      end else if (s1_vld_ff) begin
         cuts_ff <= cuts_in;
         max_ff  <= max_in;
         if (cnt_wr) begin
            cnt_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- cost pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         c2_vld_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
         c4_vld_ff <= 1'b0;
      end else begin
         c2_vld_ff <= s1_end;
         c3_vld_ff <= c2_vld_ff;
         c4_vld_ff <= c3_vld_ff;
      end
   end

   // Capture the finished path totals and the weight of its last vertex.
   always_ff @(posedge clock) begin
      if (s1_end) begin
         c2_cuts_ff   <= cuts_in;
         c2_max_ff    <= max_in;
         c2_weight_ff <= s1_weight_ff;
      end
   end

   // Repeated entries beyond the first.
   assign c2_rep = (c2_max_ff == '0) ? '0 : c2_max_ff - 1'b1;

   // Two products: timing factor times weight (16x16), and snaking factor times repeats (16xCOUNT_BITS).
   always_ff @(posedge clock) begin
      if (c2_vld_ff) begin
         c3_cuts_ff  <= c2_cuts_ff;
         c3_max_ff   <= c2_max_ff;
         c3_p1_ff    <= P1_W'(timing_factor_ff) * P1_W'(c2_weight_ff);
         c3_snake_ff <= S_W'(snaking_factor_ff) * S_W'(c2_rep);
      end
   end

   // Timing term: the weighted factor times the cut count.
   always_ff @(posedge clock) begin
      if (c3_vld_ff) begin
         c4_cuts_ff   <= c3_cuts_ff;
         c4_max_ff    <= c3_max_ff;
         c4_timing_ff <= T_W'(c3_p1_ff) * T_W'(c3_cuts_ff);
         c4_snake_ff  <= c3_snake_ff;
      end
   end

   // Saturating sum; a path that never left its block costs nothing.
   assign cost_sum = SUM_W'(c4_timing_ff) + (SUM_W'(c4_snake_ff) << SNAKE_SH);

   always_comb begin
      if (c4_cuts_ff == '0) begin
         cost_in = '0;
      end else if (cost_sum > SUM_W'(ppcc_pkg::COST_MAX)) begin
         cost_in = ppcc_pkg::COST_MAX;
      end else begin
         cost_in = cost_sum[ppcc_pkg::COST_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (c4_vld_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c4_vld_ff) begin
         rsp_cost_ff <= cost_in;
         rsp_cuts_ff <= clip_cnt(c4_cuts_ff);
         rsp_max_ff  <= clip_cnt(c4_max_ff);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {
      (ppcc_pkg::RSP_TDATA_W - ppcc_pkg::COST_W - 2 * ppcc_pkg::OUT_CNT_W)'(0),
      rsp_max_ff, rsp_cuts_ff, rsp_cost_ff
   };

   // ---------------------------------------------------------------- checks
`ifndef SYNTH
   // The end vertex leaves no per-path state behind.
   a_path_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_end |=> (cuts_ff == '0) && (max_ff == '0) && (cnt_vld_ff == '0))
      else $error("per-path state not cleared after end vertex");

   // A new visit never reads a row whose write back is still pending.
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_visit && in_counted && cnt_wr && (in_addr == s1_addr_ff)))
      else $error("counter read of a visit overlaps a write of the same row");

   // Each captured path passes through the c3 and c4 stages into the output register.
   a_cost_latency: assert property (@(posedge clock) disable iff (reset)
      c2_vld_ff |-> ##3 rsp_vld_ff)
      else $error("cost pipeline lost a result");

   // At most one result is in the cost pipeline or output register.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({c2_vld_ff, c3_vld_ff, c4_vld_ff, rsp_vld_ff}))
      else $error("more than one result in flight");

   // A result without cuts carries zero cost.
   a_zero_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_cuts_ff == '0)) |-> (rsp_cost_ff == '0))
      else $error("nonzero cost on a path without cuts");
`endif

endmodule

`default_nettype wire
